// ----- src/rgb_to_hsv_pixel_unit_assert.svh -----
// assertion macros for the rgb to hsv pixel unit
// used by the back end, no other dependencies
`ifndef RGB_TO_HSV_PIXEL_UNIT_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_UNIT_ASSERT_SVH

`define RHP_ASSERT_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");

`define RHP_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");

`endif

// ----- src/rhp_pkg.sv -----
// shared constants and types for the rgb to hsv pixel unit
// no dependencies
package rhp_pkg;
   localparam int LEVEL_BITS_DEF = 8;
   localparam int HUE_BITS = 16;
   localparam int SAT_BITS = 17;
   localparam int FRAC_BITS = 16;
   localparam int QUEUE_DEPTH = 2;
endpackage

// ----- src/rhp_front.sv -----
// front end: takes a pixel, finds max, chroma and hue numerator
// depends on rhp_pkg
module rhp_front #(
   parameter int LEVEL_BITS = rhp_pkg::LEVEL_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [LEVEL_BITS-1:0]   req_red_level,
   input  logic [LEVEL_BITS-1:0]   req_green_level,
   input  logic [LEVEL_BITS-1:0]   req_blue_level,
   output logic                    cls_valid,
   input  logic                    cls_stall,
   output logic [LEVEL_BITS-1:0]   cls_value,
   output logic [LEVEL_BITS-1:0]   cls_chroma,
   output logic [LEVEL_BITS+2:0]   cls_num
);
   import rhp_pkg::*;
   localparam int NB = LEVEL_BITS + 3;
   logic                  valid_ff, valid_in;
   logic [LEVEL_BITS-1:0] value_ff, value_in, chroma_ff, chroma_in, mn;
   logic [NB-1:0]         num_ff, num_in, r, g, b, c;

   assign req_stall = valid_ff && cls_stall;

   always_comb begin
      r = NB'(req_red_level);
      g = NB'(req_green_level);
      b = NB'(req_blue_level);
      value_in = req_red_level;
      if (req_green_level > value_in) value_in = req_green_level;
      if (req_blue_level > value_in) value_in = req_blue_level;
      mn = req_red_level;
      if (req_green_level < mn) mn = req_green_level;
      if (req_blue_level < mn) mn = req_blue_level;
      chroma_in = value_in - mn;
      c = NB'(chroma_in);
      priority if (value_in == req_red_level) begin
         if (g >= b) num_in = g - b;
         else num_in = (c << 2) + (c << 1) - (b - g);
      end else if (value_in == req_green_level) begin
         num_in = (c << 1) + b - r;
      end else begin
         num_in = (c << 2) + r - g;
      end
      valid_in = valid_ff;
      if (!req_stall) valid_in = req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (!req_stall && req_valid) begin
         value_ff <= value_in;
         chroma_ff <= chroma_in;
         num_ff <= num_in;
      end
   end

   assign cls_valid = valid_ff;
   assign cls_value = value_ff;
   assign cls_chroma = chroma_ff;
   assign cls_num = num_ff;
endmodule

// ----- src/rhp_queue.sv -----
// two-entry queue between front and back ends
// depends on rhp_pkg
module rhp_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_stall,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_stall,
   output logic [WIDTH-1:0] out_data
);
   import rhp_pkg::*;
   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;

   assign in_stall = (cnt_ff == 2'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data = mem_ff[rp_ff];
   assign push = in_valid && !in_stall;
   assign pop = out_valid && !out_stall;

   always_comb begin
      wp_in = wp_ff ^ push;
      rp_in = rp_ff ^ pop;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule

// ----- src/rhp_back.sv -----
// back end: pipelined restoring dividers for saturation and hue
// depends on rhp_pkg and the assertion header
`include "rgb_to_hsv_pixel_unit_assert.svh"
module rhp_back #(
   parameter int LEVEL_BITS = rhp_pkg::LEVEL_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_stall,
   input  logic [LEVEL_BITS-1:0]     in_value,
   input  logic [LEVEL_BITS-1:0]     in_chroma,
   input  logic [LEVEL_BITS+2:0]     in_num,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [rhp_pkg::HUE_BITS-1:0] rsp_hue_turn,
   output logic [rhp_pkg::SAT_BITS-1:0] rsp_saturation_q16,
   output logic [LEVEL_BITS-1:0]     rsp_value_level
);
   import rhp_pkg::*;
   localparam int STEPS = FRAC_BITS + 1;
   localparam int RW = LEVEL_BITS + 4;
   logic                  valid_ff [STEPS+1];
   logic [RW-1:0]         srem_ff [STEPS+1];
   logic [RW-1:0]         hrem_ff [STEPS+1];
   logic [SAT_BITS-1:0]   sq_ff [STEPS+1];
   logic [SAT_BITS-1:0]   hq_ff [STEPS+1];
   logic [LEVEL_BITS-1:0] val_ff [STEPS+1];
   logic [RW-1:0]         hden_ff [STEPS+1];
   logic                  advance;

   assign advance = !(valid_ff[STEPS] && rsp_stall);
   assign in_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= STEPS; i++) valid_ff[i] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i <= STEPS; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   // stage 0 loads, stage i makes one quotient bit from msb down
   always_ff @(posedge clock) begin
      if (advance) begin
         srem_ff[0] <= RW'(in_chroma);
         hrem_ff[0] <= RW'(in_num);
         sq_ff[0] <= '0;
         hq_ff[0] <= '0;
         val_ff[0] <= in_value;
         hden_ff[0] <= (in_chroma == '0) ? '0 : RW'(in_chroma) * RW'(6);
         for (int i = 1; i <= STEPS; i++) begin
            logic [RW:0] st, ht;
            st = {srem_ff[i-1], 1'b0};
            ht = {hrem_ff[i-1], 1'b0};
            if (i == 1) begin
               st = {1'b0, srem_ff[i-1]};
               ht = {1'b0, hrem_ff[i-1]};
            end
            val_ff[i] <= val_ff[i-1];
            hden_ff[i] <= hden_ff[i-1];
            if (val_ff[i-1] != '0 && st >= (RW+1)'(val_ff[i-1])) begin
               srem_ff[i] <= RW'(st - (RW+1)'(val_ff[i-1]));
               sq_ff[i] <= {sq_ff[i-1][SAT_BITS-2:0], 1'b1};
            end else begin
               srem_ff[i] <= RW'(st);
               sq_ff[i] <= {sq_ff[i-1][SAT_BITS-2:0], 1'b0};
            end
            if (hden_ff[i-1] != '0 && ht >= (RW+1)'(hden_ff[i-1])) begin
               hrem_ff[i] <= RW'(ht - (RW+1)'(hden_ff[i-1]));
               hq_ff[i] <= {hq_ff[i-1][SAT_BITS-2:0], 1'b1};
            end else begin
               hrem_ff[i] <= RW'(ht);
               hq_ff[i] <= {hq_ff[i-1][SAT_BITS-2:0], 1'b0};
            end
         end
      end
   end

   assign rsp_valid = valid_ff[STEPS];
   assign rsp_saturation_q16 = (val_ff[STEPS] == '0) ? '0 : sq_ff[STEPS];
   assign rsp_hue_turn = (hden_ff[STEPS] == '0) ? '0 : hq_ff[STEPS][HUE_BITS-1:0];
   assign rsp_value_level = val_ff[STEPS];

   `RHP_ASSERT_IMPL(a_sat_le_one, clock, reset, rsp_valid,
      rsp_saturation_q16 <= SAT_BITS'(1 << FRAC_BITS))
   `RHP_ASSERT_IMPL(a_black_zero, clock, reset, rsp_valid && rsp_value_level == '0,
      rsp_saturation_q16 == '0 && rsp_hue_turn == '0)
   `RHP_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_hue_turn) && $stable(rsp_saturation_q16))
endmodule

// ----- src/rgb_to_hsv_pixel_unit.sv -----
// rgb to hsv pixel converter: one pixel per clock unless rsp_stall holds the pipeline
// (front register, two-entry queue, load stage and 17-stage divider pipeline), no reset pass.
// depends on rhp_pkg, rhp_front, rhp_queue, rhp_back
module rgb_to_hsv_pixel_unit #(
   parameter int LEVEL_BITS = rhp_pkg::LEVEL_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [LEVEL_BITS-1:0]         req_red_level,
   input  logic [LEVEL_BITS-1:0]         req_green_level,
   input  logic [LEVEL_BITS-1:0]         req_blue_level,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rhp_pkg::HUE_BITS-1:0]  rsp_hue_turn,
   output logic [rhp_pkg::SAT_BITS-1:0]  rsp_saturation_q16,
   output logic [LEVEL_BITS-1:0]         rsp_value_level
);
   import rhp_pkg::*;
   localparam int QW = 3 * LEVEL_BITS + 3;
   logic                  f_valid, f_stall, q_valid, q_stall;
   logic [LEVEL_BITS-1:0] f_value, f_chroma;
   logic [LEVEL_BITS+2:0] f_num;
   logic [QW-1:0]         q_data;

   rhp_front #(.LEVEL_BITS(LEVEL_BITS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_red_level, .req_green_level,
      .req_blue_level, .cls_valid(f_valid), .cls_stall(f_stall),
      .cls_value(f_value), .cls_chroma(f_chroma), .cls_num(f_num));

   rhp_queue #(.WIDTH(QW)) u_queue (
      .clock, .reset, .in_valid(f_valid), .in_stall(f_stall),
      .in_data({f_value, f_chroma, f_num}), .out_valid(q_valid),
      .out_stall(q_stall), .out_data(q_data));

   rhp_back #(.LEVEL_BITS(LEVEL_BITS)) u_back (
      .clock, .reset, .in_valid(q_valid), .in_stall(q_stall),
      .in_value(q_data[QW-1 -: LEVEL_BITS]),
      .in_chroma(q_data[LEVEL_BITS+3 +: LEVEL_BITS]),
      .in_num(q_data[LEVEL_BITS+2:0]),
      .rsp_valid, .rsp_stall, .rsp_hue_turn, .rsp_saturation_q16, .rsp_value_level);
endmodule
